/* rtl/cms_pkg.sv */
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants for the Cipolla square root unit
// Holds the beat structs, the field width and the search bound.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int MOD_BITS = 31;
  localparam int SEARCH_LIMIT = 1024;
  localparam int TRY_BITS = 11;

  typedef logic [MOD_BITS-1:0] word_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] value_a;
    logic [MOD_BITS-1:0] modulus_p;
  } in_beat_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] root;
    logic                not_residue;
    logic                last;
  } out_beat_t;

endpackage

/* rtl/cms_mulmod.sv */
// ----------------------------------------------------------------------------
// cms_mulmod: shift-and-add modular multiplier
// Computes x*y mod m one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cms_mulmod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cms_pkg::word_t x,
  input  cms_pkg::word_t y,
  input  cms_pkg::word_t m,
  output logic           done,
  output cms_pkg::word_t result
);
  import cms_pkg::*;

  logic [MOD_BITS-1:0] acc_r, acc_nxt, xs_r, xs_nxt, ys_r, ys_nxt, m_r;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [MOD_BITS:0]   acc_sum, x_dbl;

  // One step: conditional add of x, then double x, both reduced once.
  always_comb begin
    acc_sum  = {1'b0, acc_r} + {1'b0, xs_r};
    x_dbl    = {xs_r, 1'b0};
    acc_nxt  = acc_r;
    xs_nxt   = xs_r;
    ys_nxt   = ys_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      xs_nxt   = x;
      ys_nxt   = y;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ys_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (ys_r[0]) begin
          acc_nxt = (acc_sum >= {1'b0, m_r}) ? MOD_BITS'(acc_sum - {1'b0, m_r})
                                             : acc_sum[MOD_BITS-1:0];
        end
        xs_nxt = (x_dbl >= {1'b0, m_r}) ? MOD_BITS'(x_dbl - {1'b0, m_r})
                                        : x_dbl[MOD_BITS-1:0];
        ys_nxt = ys_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    if (start) begin
      m_r <= m;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

  // The operand that stays below m must stay reduced while stepping.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> acc_r < m_r)
    else $error("accumulator left the residue range");
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done while still busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("start did not raise busy");

endmodule

/* rtl/cipolla_modular_sqrt_unit.sv */
// Cost: every modular multiplication runs on the shared shift-add unit. An Euler
// test costs up to 60 of them, each tried b one more, and the extension power up
// to 9 per exponent bit; a long search for b (up to 1024 tries) stretches that.
// Throughput: one item at a time; in_ready stays low until its last beat is taken.
// Reset: synchronous, active low; clears the sequencer, multiplier start and output valid.
// ----------------------------------------------------------------------------
// cipolla_modular_sqrt_unit: modular square root by Cipolla's method
// A sequencer drives one shared modular multiplier through the reduction of a,
// Euler tests, the deterministic search for b and the power in the quadratic extension.
// ----------------------------------------------------------------------------
module cipolla_modular_sqrt_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cms_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cms_pkg::out_beat_t out_data
);
  import cms_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_REDUCE = 14'b00000000000010,
    S_PSTEP  = 14'b00000000000100,
    S_PMUL   = 14'b00000000001000,
    S_PSQR   = 14'b00000000010000,
    S_BSQ    = 14'b00000000100000,
    S_XSTEP  = 14'b00000001000000,
    S_XMUL   = 14'b00000010000000,
    S_OUT1   = 14'b00000100000000,
    S_OUT2   = 14'b00001000000000,
    S_FAIL   = 14'b00010000000000,
    S_TRIV   = 14'b00100000000000,
    S_ORDER  = 14'b01000000000000,
    S_WAIT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [MOD_BITS-1:0] a_r, p_r, ar_r, b_r, d_r;
  logic [MOD_BITS-1:0] base_r, acc_r, e_r;
  logic [MOD_BITS-1:0] xr_r, xi_r, zr_r, zi_r, t_r;
  logic [MOD_BITS-1:0] r_r, s_r;
  logic [TRY_BITS-1:0] tries_r;
  logic                search_r;   // Euler test belongs to the b search
  logic [3:0]          op_r;       // micro-op index within a sequence
  logic                wait_ret_r; // a multiply issued from S_XMUL is awaited
  logic                out_vld_r;
  out_beat_t           out_r;

  logic                mm_start;
  word_t               mm_x, mm_y, mm_res;
  logic                mm_done;

  cms_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .x(mm_x), .y(mm_y),
    .m(p_r), .done(mm_done), .result(mm_res)
  );

  // Helper for modular add on reduced operands.
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    logic [MOD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, m}) ? MOD_BITS'(s - {1'b0, m}) : s[MOD_BITS-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE) && !out_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  logic [MOD_BITS-1:0] half_dn, half_up, tlimit;
  assign half_dn = p_r >> 1;
  assign half_up = MOD_BITS'(({1'b0, p_r} + 1'b1) >> 1);
  assign tlimit  = (p_r < MOD_BITS'(SEARCH_LIMIT)) ? p_r : MOD_BITS'(SEARCH_LIMIT);

  // Sequencer: every multiplication goes through the shared multiplier.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_vld_r  <= 1'b0;
      mm_start   <= 1'b0;
      op_r       <= 4'd0;
      wait_ret_r <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      if (out_vld_r && out_ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            a_r <= in_data.value_a;
            p_r <= in_data.modulus_p;
            if (in_data.value_a <= MOD_BITS'(1) || in_data.modulus_p == MOD_BITS'(2)) begin
              state_r <= S_TRIV;
            end else if (in_data.modulus_p < MOD_BITS'(2)) begin
              state_r <= S_FAIL;
            end else begin
              ar_r    <= in_data.value_a;
              state_r <= S_REDUCE;
            end
          end
        end
        // a mod p by repeated compare-subtract is too slow; use a*1 on the unit.
        S_REDUCE: begin
          if (!mm_start && op_r == 4'd0) begin
            // a may exceed p: reduce through shift-add of 1 by a (acc < p kept)
            mm_x     <= MOD_BITS'(1);
            mm_y     <= a_r;
            mm_start <= 1'b1;
            op_r     <= 4'd1;
          end else if (mm_done) begin
            ar_r     <= mm_res;
            base_r   <= mm_res;
            acc_r    <= MOD_BITS'(1);
            e_r      <= half_dn;
            search_r <= 1'b0;
            op_r     <= 4'd0;
            state_r  <= S_PSTEP;
          end
        end
        // Square and multiply power: acc = base^e mod p.
        S_PSTEP: begin
          if (e_r == '0) begin
            if (acc_r != MOD_BITS'(1)) begin
              if (search_r) begin
                // d is a non-residue or zero: start the extension power
                xr_r    <= b_r;
                xi_r    <= MOD_BITS'(1);
                zr_r    <= MOD_BITS'(1);
                zi_r    <= '0;
                e_r     <= half_up;
                op_r    <= 4'd0;
                state_r <= S_XSTEP;
              end else begin
                state_r <= S_FAIL;
              end
            end else if (search_r) begin
              if (tries_r + 1'b1 >= TRY_BITS'(tlimit)) begin
                state_r <= S_FAIL;
              end else begin
                tries_r <= tries_r + 1'b1;
                b_r     <= b_r + 1'b1;
                op_r    <= 4'd0;
                state_r <= S_BSQ;
              end
            end else begin
              b_r      <= '0;
              tries_r  <= '0;
              search_r <= 1'b1;
              op_r     <= 4'd0;
              state_r  <= S_BSQ;
            end
          end else if (e_r[0]) begin
            mm_x     <= acc_r;
            mm_y     <= base_r;
            mm_start <= 1'b1;
            state_r  <= S_PMUL;
          end else begin
            mm_x     <= base_r;
            mm_y     <= base_r;
            mm_start <= 1'b1;
            state_r  <= S_PSQR;
          end
        end
        S_PMUL: begin
          if (mm_done) begin
            acc_r    <= mm_res;
            mm_x     <= base_r;
            mm_y     <= base_r;
            mm_start <= 1'b1;
            state_r  <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (mm_done) begin
            base_r  <= mm_res;
            e_r     <= e_r >> 1;
            state_r <= S_PSTEP;
          end
        end
        // d = b*b - a mod p, then Euler test on d.
        S_BSQ: begin
          if (op_r == 4'd0) begin
            mm_x     <= b_r;
            mm_y     <= b_r;
            mm_start <= 1'b1;
            op_r     <= 4'd1;
          end else if (mm_done) begin
            d_r     <= (mm_res >= ar_r) ? MOD_BITS'(mm_res - ar_r)
                                        : MOD_BITS'(mm_res + (p_r - ar_r));
            base_r  <= (mm_res >= ar_r) ? MOD_BITS'(mm_res - ar_r)
                                        : MOD_BITS'(mm_res + (p_r - ar_r));
            acc_r   <= MOD_BITS'(1);
            e_r     <= half_dn;
            state_r <= S_PSTEP;
          end
        end
        // Extension power: z = (b + w)^e with w^2 = d. Micro-ops per bit:
        // multiply step (if bit set): 1 zr*xr 2 zi*xi 3 d*t 4 zr*xi 5 zi*xr
        // square step: 6 xr*xr 7 xi*xi 8 d*t 9 xr*xi
        S_XSTEP: begin
          if (e_r == '0) begin
            r_r     <= zr_r;
            s_r     <= MOD_BITS'(p_r - zr_r);
            state_r <= S_ORDER;
          end else begin
            op_r    <= e_r[0] ? 4'd1 : 4'd6;
            state_r <= S_XMUL;
          end
        end
        S_XMUL: begin
          if (!wait_ret_r) begin
            mm_start   <= 1'b1;
            wait_ret_r <= 1'b1;
            unique case (op_r)
              4'd1: begin mm_x <= zr_r; mm_y <= xr_r; end
              4'd2: begin mm_x <= zi_r; mm_y <= xi_r; end
              4'd3: begin mm_x <= d_r;  mm_y <= t_r;  end
              4'd4: begin mm_x <= zr_r; mm_y <= xi_r; end
              4'd5: begin mm_x <= zi_r; mm_y <= xr_r; end
              4'd6: begin mm_x <= xr_r; mm_y <= xr_r; end
              4'd7: begin mm_x <= xi_r; mm_y <= xi_r; end
              4'd8: begin mm_x <= d_r;  mm_y <= t_r;  end
              default: begin mm_x <= xr_r; mm_y <= xi_r; end
            endcase
          end else if (mm_done) begin
            wait_ret_r <= 1'b0;
            op_r       <= op_r + 1'b1;
            unique case (op_r)
              4'd1: r_r <= mm_res;
              4'd2: t_r <= mm_res;
              4'd3: r_r <= add_mod(r_r, mm_res, p_r);
              4'd4: s_r <= mm_res;
              4'd5: begin
                zi_r <= add_mod(s_r, mm_res, p_r);
                zr_r <= r_r;
              end
              4'd6: r_r <= mm_res;
              4'd7: t_r <= mm_res;
              4'd8: r_r <= add_mod(r_r, mm_res, p_r);
              default: begin
                xi_r    <= add_mod(mm_res, mm_res, p_r);
                xr_r    <= r_r;
                e_r     <= e_r >> 1;
                state_r <= S_XSTEP;
              end
            endcase
          end
        end
        S_ORDER: begin
          if (r_r > s_r) begin
            r_r <= s_r;
            s_r <= r_r;
          end
          state_r <= S_OUT1;
        end
        S_OUT1: begin
          if (!out_vld_r) begin
            out_r     <= '{root: r_r, not_residue: 1'b0, last: 1'b0};
            out_vld_r <= 1'b1;
            state_r   <= S_OUT2;
          end
        end
        S_OUT2: begin
          if (!out_vld_r || out_ready) begin
            out_r     <= '{root: s_r, not_residue: 1'b0, last: 1'b1};
            out_vld_r <= 1'b1;
            state_r   <= S_WAIT;
          end
        end
        S_FAIL: begin
          out_r     <= '{root: '0, not_residue: 1'b1, last: 1'b1};
          out_vld_r <= 1'b1;
          state_r   <= S_WAIT;
        end
        S_TRIV: begin
          out_r     <= '{root: a_r, not_residue: 1'b0, last: 1'b1};
          out_vld_r <= 1'b1;
          state_r   <= S_WAIT;
        end
        S_WAIT: begin
          op_r       <= 4'd0;
          wait_ret_r <= 1'b0;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // No new item while any result beat is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");
  // A not-residue beat always carries a zero root and closes the item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.not_residue |-> out_data.root == '0 && out_data.last)
    else $error("bad not-residue beat");
  // The first root of a pair never exceeds the second.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT1 |-> r_r <= s_r)
    else $error("roots out of order");
  // The multiplier is only started from a working state.
  assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> state_r != S_IDLE && state_r != S_WAIT)
    else $error("multiplier started while idle");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cipolla_modular_sqrt_unit
// Runs a directed table of edge cases and then random prime moduli, some
// values built as squares. Each beat is checked against a square-root model
// kept inside the bench. Both channels take random gaps, there is one long
// receiver stall, and there is one pause until the block drains.
// ----------------------------------------------------------------------------
module tb;
  import cms_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int N_RANDOM = 118;
  localparam int HOLD_CYCLES = 40000;

  // One directed case, with the expected single result where it is obvious.
  typedef struct {
    word_t a;
    word_t p;
    bit    typed;
    word_t root;
    bit    nr;
  } case_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  out_beat_t root_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        n_in = 0, n_out = 0, n_pairs = 0, n_nonres = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;

  cipolla_modular_sqrt_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Arithmetic modulo a modulus of up to 31 bits; operands are below 2^31, so the
  // product fits in 64 bits.
  function automatic longint unsigned mulm(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    return (x * y) % m;
  endfunction

  function automatic longint unsigned powm(longint unsigned b, longint unsigned e,
                                           longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulm(acc, b, m);
      b = mulm(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Rational part of (b + w)^e, where w*w = d.
  function automatic longint unsigned ext_pow(longint unsigned b, longint unsigned d,
                                              longint unsigned e, longint unsigned m);
    longint unsigned xr, xi, ar, ai, nr, ni;
    xr = b; xi = 1 % m; ar = 1 % m; ai = 0;
    while (e != 0) begin
      if (e[0]) begin
        nr = (mulm(ar, xr, m) + mulm(d, mulm(ai, xi, m), m)) % m;
        ni = (mulm(ar, xi, m) + mulm(ai, xr, m)) % m;
        ar = nr; ai = ni;
      end
      nr = (mulm(xr, xr, m) + mulm(d, mulm(xi, xi, m), m)) % m;
      ni = (2 * mulm(xr, xi, m)) % m;
      xr = nr; xi = ni;
      e = e >> 1;
    end
    return ar;
  endfunction

  // Push the expected root beats for one value and modulus.
  function automatic void predict_roots(word_t a_in, word_t p_in);
    longint unsigned a, p, ar, b, d, tries, r, s;
    bit found;
    out_beat_t x;
    a = a_in; p = p_in; found = 1'b0; d = 0; b = 0;
    x = '0; x.last = 1'b1;
    if (a <= 1 || p == 2) begin
      x.root = a_in;
      root_q.push_back(x);
      return;
    end
    x.not_residue = 1'b1;
    if (p < 2) begin
      root_q.push_back(x);
      return;
    end
    ar = a % p;
    if (powm(ar, (p - 1) / 2, p) != 1) begin
      root_q.push_back(x);
      return;
    end
    tries = (p < SEARCH_LIMIT) ? p : SEARCH_LIMIT;
    while (b < tries && !found) begin
      d = (mulm(b, b, p) + p - ar) % p;
      if (powm(d, (p - 1) / 2, p) != 1) found = 1'b1;
      else b++;
    end
    if (!found) begin
      root_q.push_back(x);
      return;
    end
    r = ext_pow(b, d, (p + 1) / 2, p);
    s = p - r;
    if (r > s) begin
      d = r; r = s; s = d;
    end
    x = '0;
    x.root = word_t'(r);
    root_q.push_back(x);
    x.root = word_t'(s);
    x.last = 1'b1;
    root_q.push_back(x);
  endfunction

  function automatic bit is_prime(longint unsigned n);
    longint unsigned k;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (k = 3; k * k <= n; k += 2)
      if (n % k == 0) return 1'b0;
    return 1'b1;
  endfunction

  // A random prime of at least the given bit width, and at least 3.
  function automatic word_t rand_prime(int w);
    longint unsigned n;
    if (w <= 2) return word_t'(3);
    n = (longint'($urandom) & ((64'd1 << w) - 1)) | (64'd1 << (w - 1)) | 1;
    while (!is_prime(n)) begin
      n += 2;
      if (n >= (64'd1 << 31)) n = 2147483647;
    end
    return word_t'(n);
  endfunction

  // Present one beat at the falling edge and hold it until it is taken.
  // Valid stays high into the next beat when no gap is drawn.
  task automatic send_beat(word_t a, word_t p);
    int gap;
    case ($urandom_range(0, 19))
      0:       gap = $urandom_range(20, 300);
      1, 2, 3: gap = $urandom_range(1, 4);
      default: gap = 0;
    endcase
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value_a: a, modulus_p: p};
    do @(posedge clk); while (!in_ready);
    n_in++;
  endtask

  // Drop valid at the next falling edge once the last offered beat is taken.
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Acceptance watchdog and output checker.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("cipolla_modular_sqrt_unit test failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (root_q.size() == 0) begin
        $error("result beat with no expectation: root=%0d", out_data.root);
        errors++;
      end else begin
        out_beat_t e;
        e = root_q.pop_front();
        if (out_data.root !== e.root) begin
          $error("root: expected %0d, got %0d", e.root, out_data.root);
          errors++;
        end
        if (out_data.not_residue !== e.not_residue) begin
          $error("not_residue: expected %0b, got %0b", e.not_residue, out_data.not_residue);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(20, 300);
        1, 2, 3: gap = $urandom_range(1, 4);
        default: gap = 0;
      endcase
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Stimulus.
  initial begin
    case_t cases[$];
    case_t c;
    word_t a, p, x;
    int sel;
    cases = '{
      '{31'd0, 31'd7, 1'b1, 31'd0, 1'b0},                 // zero value
      '{31'd1, 31'd2147483647, 1'b1, 31'd1, 1'b0},        // one, largest prime
      '{31'h7fffffff, 31'd2, 1'b1, 31'h7fffffff, 1'b0},   // modulus two, unreduced
      '{31'd5, 31'd2, 1'b1, 31'd5, 1'b0},
      '{31'd14, 31'd7, 1'b1, 31'd0, 1'b1},                // multiple of p
      '{31'd2, 31'd3, 1'b1, 31'd0, 1'b1},                 // non-residue
      '{31'h7fffffff, 31'd2147483647, 1'b1, 31'd0, 1'b1}, // p itself
      '{31'd3, 31'd7, 1'b1, 31'd0, 1'b1},
      '{31'd4, 31'd13, 1'b0, 31'd0, 1'b0},                // search hits d of zero
      '{31'd2, 31'd7, 1'b0, 31'd0, 1'b0},
      '{31'd4, 31'd5, 1'b0, 31'd0, 1'b0},
      '{31'd2147483646, 31'd2147483647, 1'b0, 31'd0, 1'b0},
      '{31'd2, 31'd2147483647, 1'b0, 31'd0, 1'b0},
      '{31'h55555555, 31'd2147483629, 1'b0, 31'd0, 1'b0},
      '{31'd4, 31'd15, 1'b0, 31'd0, 1'b0},                // composite modulus
      '{31'd4, 31'd9, 1'b0, 31'd0, 1'b0},
      '{31'd3, 31'd11, 1'b0, 31'd0, 1'b0},
      '{31'd2147483647, 31'd3, 1'b0, 31'd0, 1'b0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (cases[i]) begin
      c = cases[i];
      if (c.typed) begin
        out_beat_t e;
        e.root = c.root; e.not_residue = c.nr; e.last = 1'b1;
        root_q.push_back(e);
      end else begin
        predict_roots(c.a, c.p);
      end
      send_beat(c.a, c.p);
    end

    // Random part: prime moduli, about half of the values built as squares.
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) p = 31'd2;
      else if (sel < 3) p = 31'd2147483647;
      else if (sel < 8) p = rand_prime($urandom_range(2, 10));
      else p = rand_prime($urandom_range(11, 31));
      sel = $urandom_range(0, 9);
      x = word_t'($urandom);
      if (sel < 5) begin
        a = word_t'(mulm(x % p, x % p, p));
        // Add a multiple of p while it still fits.
        if ($urandom_range(0, 1) && (longint'(a) + longint'(p) < (64'd1 << 31)))
          a = a + p * word_t'($urandom_range(0, (32'h7fffffff - a) / p));
      end else if (sel < 9) begin
        a = word_t'($urandom);
      end else begin
        a = word_t'($urandom_range(0, 1));
      end
      if (i == 40) hold_req = 1'b1;
      if (i == 80) begin
        release_input();
        wait (root_q.size() == 0);
      end
      predict_roots(a, p);
      if (root_q.size() >= 2 && root_q[root_q.size() - 1].last &&
          !root_q[root_q.size() - 1].not_residue && root_q[root_q.size() - 2].last == 1'b0)
        n_pairs++;
      else if (root_q[root_q.size() - 1].not_residue)
        n_nonres++;
      send_beat(a, p);
    end
    release_input();

    wait (root_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d items, checked %0d result beats.", n_in, n_out);
    $display("Random part: %0d root pairs, %0d non-residues, one long output stall.",
             n_pairs, n_nonres);
    if (errors == 0 && root_q.size() == 0) begin
      $display("cipolla_modular_sqrt_unit test passed");
    end else begin
      $display("cipolla_modular_sqrt_unit test failed");
    end
    $finish;
  end

endmodule
